// ===== sv/assert_macros.svh =====
// Assertion macros used by the top level of the joystick conditioner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define DJC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define DJC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/djc_pkg.sv =====
// Shared constants, types and register codes for the joystick conditioner.
`default_nettype none

package djc_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int ALPHA_W     = 9;
   localparam int ALPHA_FRAC  = 8;
   localparam int DZ_W        = 11;
   localparam int FLAGS_W     = 4;
   localparam int NUM_AXES    = 4;
   localparam int NUM_STICKS  = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = (SAMPLE_BITS > DZ_W) ? SAMPLE_BITS : DZ_W;
   localparam int CMP_W       = (SAMPLE_BITS > DZ_W) ? SAMPLE_BITS : DZ_W;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};
   localparam logic [SAMPLE_BITS-1:0] MIDSCALE   = SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));
   localparam logic [SAMPLE_BITS-1:0] CENTER_RST = SAMPLE_BITS'(2048);
   localparam logic [ALPHA_W-1:0]     ALPHA_FULL = ALPHA_W'(1 << ALPHA_FRAC);
   localparam logic [ALPHA_W-1:0]     ALPHA_RST  = ALPHA_W'(64);
   localparam logic [DZ_W-1:0]        DZ_RST     = DZ_W'(100);
   localparam logic [FLAGS_W-1:0]     FLAGS_RST  = '0;

   // lane order inside a sample set
   localparam int AXIS_LX = 0;
   localparam int AXIS_LY = 1;
   localparam int AXIS_RX = 2;
   localparam int AXIS_RY = 3;

   // per-stick bit positions inside its two-bit orientation slice
   localparam int FLAG_SWAP   = 0;
   localparam int FLAG_INVERT = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_LX = 3'd0,
      CSR_CENTER_LY = 3'd1,
      CSR_CENTER_RX = 3'd2,
      CSR_CENTER_RY = 3'd3,
      CSR_ALPHA     = 3'd4,
      CSR_DEADZONE  = 3'd5,
      CSR_FLAGS     = 3'd6,
      CSR_NOMINAL   = 3'd7
   } csr_index_type;

   typedef logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] axes_type;

   typedef struct packed {
      axes_type             center;
      logic [ALPHA_W-1:0]   alpha;
      logic [DZ_W-1:0]      deadzone;
      logic [FLAGS_W-1:0]   flags;
      logic [SAMPLE_BITS-1:0] nominal;
   } cfg_type;

   // one filtered set on its way from the front to the back
   typedef struct packed {
      axes_type              filt;
      logic [NUM_STICKS-1:0] disc;
   } entry_type;

endpackage

`default_nettype wire

// ===== sv/dual_joystick_conditioner_core.sv =====
// Top level of the dual joystick conditioner: register file, front end, queue, back end.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_raw_left_x/_y, req_raw_right_x/_y
//   rsp      out        rsp_valid/rsp_stall  rsp_left_x/_y, rsp_right_x/_y
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One request per cycle unless stalled; rsp_valid rises via the queue and output register.
// The four EMA filters update in the acceptance cycle (one multiply per axis).
// A two-entry queue parts the filters from the output stage, so req stalls only when full.
// Synchronous reset returns filters to mid-scale and registers to their defaults.
// csr is always ready.
`default_nettype none
`include "assert_macros.svh"

module dual_joystick_conditioner_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [djc_pkg::SAMPLE_BITS-1:0]    req_raw_left_x,
   input  logic [djc_pkg::SAMPLE_BITS-1:0]    req_raw_left_y,
   input  logic [djc_pkg::SAMPLE_BITS-1:0]    req_raw_right_x,
   input  logic [djc_pkg::SAMPLE_BITS-1:0]    req_raw_right_y,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [djc_pkg::SAMPLE_BITS-1:0]    rsp_left_x,
   output logic [djc_pkg::SAMPLE_BITS-1:0]    rsp_left_y,
   output logic [djc_pkg::SAMPLE_BITS-1:0]    rsp_right_x,
   output logic [djc_pkg::SAMPLE_BITS-1:0]    rsp_right_y,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [djc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [djc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   djc_pkg::cfg_type   cfg_ff;
   djc_pkg::cfg_type   cfg_in;
   djc_pkg::entry_type push_entry;
   djc_pkg::entry_type pop_entry;
   logic               push;
   logic               q_full;
   logic               q_pop;
   logic               q_valid;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (djc_pkg::csr_index_type'(csr_index))
            djc_pkg::CSR_CENTER_LX:
               cfg_in.center[djc_pkg::AXIS_LX] = csr_wdata[djc_pkg::SAMPLE_BITS-1:0];
            djc_pkg::CSR_CENTER_LY:
               cfg_in.center[djc_pkg::AXIS_LY] = csr_wdata[djc_pkg::SAMPLE_BITS-1:0];
            djc_pkg::CSR_CENTER_RX:
               cfg_in.center[djc_pkg::AXIS_RX] = csr_wdata[djc_pkg::SAMPLE_BITS-1:0];
            djc_pkg::CSR_CENTER_RY:
               cfg_in.center[djc_pkg::AXIS_RY] = csr_wdata[djc_pkg::SAMPLE_BITS-1:0];
            djc_pkg::CSR_ALPHA:    cfg_in.alpha    = csr_wdata[djc_pkg::ALPHA_W-1:0];
            djc_pkg::CSR_DEADZONE: cfg_in.deadzone = csr_wdata[djc_pkg::DZ_W-1:0];
            djc_pkg::CSR_FLAGS:    cfg_in.flags    = csr_wdata[djc_pkg::FLAGS_W-1:0];
            djc_pkg::CSR_NOMINAL:  cfg_in.nominal  = csr_wdata[djc_pkg::SAMPLE_BITS-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < djc_pkg::NUM_AXES; i++) begin
            cfg_ff.center[i] <= djc_pkg::CENTER_RST;
         end
         cfg_ff.alpha    <= djc_pkg::ALPHA_RST;
         cfg_ff.deadzone <= djc_pkg::DZ_RST;
         cfg_ff.flags    <= djc_pkg::FLAGS_RST;
         cfg_ff.nominal  <= djc_pkg::CENTER_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   djc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_raw_left_x  (req_raw_left_x),
      .req_raw_left_y  (req_raw_left_y),
      .req_raw_right_x (req_raw_right_x),
      .req_raw_right_y (req_raw_right_y),
      .alpha           (cfg_ff.alpha),
      .q_full          (q_full),
      .push            (push),
      .push_entry      (push_entry)
   );

   djc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (pop_entry)
   );

   djc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_entry     (pop_entry),
      .q_pop       (q_pop),
      .cfg         (cfg_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_left_x  (rsp_left_x),
      .rsp_left_y  (rsp_left_y),
      .rsp_right_x (rsp_right_x),
      .rsp_right_y (rsp_right_y)
   );

   // an accepted request is queued for the back end next cycle
   `DJC_ASSERT_NEXT(a_push_lands, clock, reset, req_valid && !req_stall, q_valid, "request lost before queue")
   // queued work moves to the output register whenever that register is free
   `DJC_ASSERT_NEXT(a_drain, clock, reset, q_valid && !(rsp_valid && rsp_stall), rsp_valid, "queue did not drain")
   // front stalls only on a full queue, never on an empty one
   `DJC_ASSERT_NOW(a_stall_full, clock, reset, req_stall, q_valid, "stall with empty queue")

endmodule

`default_nettype wire

// ===== sv/djc_front.sv =====
// Front end: accepts a raw sample set, runs the four EMA filters, tags disconnected sticks.
`default_nettype none

module djc_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [djc_pkg::SAMPLE_BITS-1:0] req_raw_left_x,
   input  logic [djc_pkg::SAMPLE_BITS-1:0] req_raw_left_y,
   input  logic [djc_pkg::SAMPLE_BITS-1:0] req_raw_right_x,
   input  logic [djc_pkg::SAMPLE_BITS-1:0] req_raw_right_y,
   input  logic [djc_pkg::ALPHA_W-1:0]  alpha,
   input  logic                         q_full,
   output logic                         push,
   output djc_pkg::entry_type           push_entry
);

   localparam int PROD_W = djc_pkg::SAMPLE_BITS + djc_pkg::ALPHA_W + 2;

   djc_pkg::axes_type               raw;
   djc_pkg::axes_type               filt_ff;
   djc_pkg::axes_type               filt_in;
   logic [djc_pkg::ALPHA_W-1:0]     alpha_sat;

   assign raw[djc_pkg::AXIS_LX] = req_raw_left_x;
   assign raw[djc_pkg::AXIS_LY] = req_raw_left_y;
   assign raw[djc_pkg::AXIS_RX] = req_raw_right_x;
   assign raw[djc_pkg::AXIS_RY] = req_raw_right_y;

   assign req_stall = q_full;
   assign push      = req_valid & ~q_full;

   assign alpha_sat = (alpha > djc_pkg::ALPHA_FULL) ? djc_pkg::ALPHA_FULL : alpha;

   // filt' = filt + floor(alpha * (raw - filt) / 256), same as the weighted sum
   for (genvar g = 0; g < djc_pkg::NUM_AXES; g++) begin : g_lane
      logic signed [djc_pkg::SAMPLE_BITS:0] diff;
      logic signed [djc_pkg::ALPHA_W:0]     a_s;
      logic signed [PROD_W-1:0]             prod;
      logic signed [PROD_W-1:0]             step;

      assign diff    = $signed({1'b0, raw[g]}) - $signed({1'b0, filt_ff[g]});
      assign a_s     = $signed({1'b0, alpha_sat});
      assign prod    = PROD_W'(diff) * PROD_W'(a_s);
      assign step    = prod >>> djc_pkg::ALPHA_FRAC;
      assign filt_in[g] = filt_ff[g] + step[djc_pkg::SAMPLE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < djc_pkg::NUM_AXES; i++) begin
            filt_ff[i] <= djc_pkg::MIDSCALE;
         end
      end else if (push) begin
         filt_ff <= filt_in;
      end
   end

   assign push_entry.filt = filt_in;
   assign push_entry.disc[0] = (req_raw_left_x == '0) && (req_raw_left_y == '0);
   assign push_entry.disc[1] = (req_raw_right_x == '0) && (req_raw_right_y == '0);

endmodule

`default_nettype wire

// ===== sv/djc_fifo.sv =====
// Short queue of filtered sets between the front and back ends.
`default_nettype none

module djc_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  djc_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               pop_valid,
   output djc_pkg::entry_type pop_entry
);

   localparam int PTR_W = (djc_pkg::QUEUE_DEPTH > 1) ? $clog2(djc_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(djc_pkg::QUEUE_DEPTH + 1);

   djc_pkg::entry_type mem_ff [djc_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == CNT_W'(djc_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(djc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(djc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== sv/djc_back.sv =====
// Back end: deadzone snap, mirror, swap and disconnect handling, with the result register.
`default_nettype none

module djc_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  djc_pkg::entry_type              q_entry,
   output logic                            q_pop,
   input  djc_pkg::cfg_type                cfg,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [djc_pkg::SAMPLE_BITS-1:0] rsp_left_x,
   output logic [djc_pkg::SAMPLE_BITS-1:0] rsp_left_y,
   output logic [djc_pkg::SAMPLE_BITS-1:0] rsp_right_x,
   output logic [djc_pkg::SAMPLE_BITS-1:0] rsp_right_y
);

   localparam int S = djc_pkg::SAMPLE_BITS;

   function automatic logic [S-1:0] snap(input logic [S-1:0] v, input logic [S-1:0] c,
                                         input logic [djc_pkg::DZ_W-1:0] dz,
                                         input logic [S-1:0] nom);
      logic signed [S:0] d;
      logic [S-1:0]      mag;
      d   = $signed({1'b0, v}) - $signed({1'b0, c});
      mag = d[S] ? S'(-d) : d[S-1:0];
      return (djc_pkg::CMP_W'(mag) < djc_pkg::CMP_W'(dz)) ? nom : v;
   endfunction

   // 2*nom - v, clamped to the sample range
   function automatic logic [S-1:0] mirror(input logic [S-1:0] v, input logic [S-1:0] nom);
      logic signed [S+1:0] m;
      m = $signed({1'b0, nom, 1'b0}) - $signed({2'b00, v});
      if (m[S+1]) begin
         return '0;
      end else if (m[S]) begin
         return djc_pkg::SAMPLE_MAX;
      end else begin
         return m[S-1:0];
      end
   endfunction

   logic                 rsp_valid_ff, rsp_valid_in;
   djc_pkg::axes_type    out_ff;
   djc_pkg::axes_type    out_in;

   assign q_pop        = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = q_pop || (rsp_valid_ff && rsp_stall);

   for (genvar s = 0; s < djc_pkg::NUM_STICKS; s++) begin : g_stick
      logic [S-1:0] x_snap, y_snap, x_mir, y_mir;
      logic         swap, invert;

      assign swap   = cfg.flags[2*s + djc_pkg::FLAG_SWAP];
      assign invert = cfg.flags[2*s + djc_pkg::FLAG_INVERT];

      assign x_snap = snap(q_entry.filt[2*s], cfg.center[2*s], cfg.deadzone, cfg.nominal);
      assign y_snap = snap(q_entry.filt[2*s+1], cfg.center[2*s+1], cfg.deadzone,
                           cfg.nominal);
      assign x_mir  = invert ? mirror(x_snap, cfg.nominal) : x_snap;
      assign y_mir  = invert ? mirror(y_snap, cfg.nominal) : y_snap;

      always_comb begin
         if (q_entry.disc[s]) begin
            out_in[2*s]   = cfg.nominal;
            out_in[2*s+1] = cfg.nominal;
         end else if (swap) begin
            out_in[2*s]   = y_mir;
            out_in[2*s+1] = x_mir;
         end else begin
            out_in[2*s]   = x_mir;
            out_in[2*s+1] = y_mir;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_left_x  = out_ff[djc_pkg::AXIS_LX];
   assign rsp_left_y  = out_ff[djc_pkg::AXIS_LY];
   assign rsp_right_x = out_ff[djc_pkg::AXIS_RX];
   assign rsp_right_y = out_ff[djc_pkg::AXIS_RY];

endmodule

`default_nettype wire
